### src/page_free_list_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pfla_pkg.sv
package pfla_pkg;

    localparam int FRAME_W = 36;
    localparam int COUNT_W = 17;
    localparam int BULK_W  = 7;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    typedef enum logic [1:0] {
        OP_REBUILD    = 2'd0,
        OP_ALLOC_ONE  = 2'd1,
        OP_ALLOC_BULK = 2'd2,
        OP_FREE_ONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_GIVEN     = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DONE      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Register select is paddr[3]: registers sit at byte addresses 0 and 8.
    localparam logic REG_FIRST_FRAME = 1'b0;
    localparam logic REG_POOL_PAGES  = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [FRAME_W-1:0] frame_in;
        logic [BULK_W-1:0]  bulk_count;
    } cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic [1:0]         status;
        logic               last;
        logic [COUNT_W-1:0] free_pages;
        logic [COUNT_W-1:0] total_pages;
    } result_t;

endpackage

### src/page_free_list_allocator.sv
// LIFO page allocator with a fire-and-forget result port: every result is shown for exactly one
// cycle on result with result_valid high and cannot be held off, so the receiver must take it.
// busy is high while a command is in progress; a new command is taken when start is high and
// busy is low. Timing is set by the link memory and its registered read: a free ends in
// dispatch, an alloc of one page steps through dispatch, link read and link update, a bulk
// alloc gives one result per page after a link read and update each, and a rebuild writes
// one link per cycle. Each result is registered and appears in the cycle after the last of
// these steps. The link memory needs no clearing after reset, since only entries linked by a
// rebuild are ever read. Configuration (first_frame at address 0, pool_pages at address 8)
// takes effect at the next rebuild, except first_frame, which maps frames at once.
`include "page_free_list_allocator_defines.svh"

module page_free_list_allocator
    import pfla_pkg::*;
#(
    parameter int POOL_DEPTH = 65536,
    parameter int MAX_BULK   = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 result_valid,
    output result_t              result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int BW = $clog2(MAX_BULK + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_LINK     = 5'b00100,
        S_POP_RD   = 5'b01000,
        S_POP_WAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [FRAME_W-1:0] first_frame_reg;
    logic [COUNT_W-1:0] pool_pages_reg;

    cmd_t          cmd_reg;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] free_reg, free_next;
    logic [LW-1:0] total_reg, total_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] n_reg, n_next;
    logic [BW-1:0] cnt_reg, cnt_next;
    logic [BW-1:0] k_reg, k_next;

    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [LW-1:0] ram_wdata, ram_rdata;

    logic               accept;
    logic               cfg_write;
    logic [FRAME_W-1:0] free_diff;
    logic               free_bad;
    logic [BW-1:0]      bulk_cnt;
    logic               res_emit;
    logic [1:0]         res_status;
    logic               res_last;
    logic [FRAME_W-1:0] res_frame;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        if (paddr[3] == REG_POOL_PAGES)
        begin
            prdata = PDATA_W'(pool_pages_reg);
        end
        else
        begin
            prdata = PDATA_W'(first_frame_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_reg <= '0;
            pool_pages_reg  <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_POOL_PAGES)
            begin
                pool_pages_reg <= pwdata[COUNT_W-1:0];
            end
            else
            begin
                first_frame_reg <= pwdata[FRAME_W-1:0];
            end
        end
    end

    pfla_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A free is in range when the frame is at or above first_frame and its offset is below
    // the total page count.
    assign free_diff = cmd_reg.frame_in - first_frame_reg;
    assign free_bad  = (cmd_reg.frame_in < first_frame_reg) ||
                       (free_diff >= FRAME_W'(total_reg));

    always_comb
    begin
        if (32'(cmd_reg.bulk_count) > 32'(MAX_BULK))
        begin
            bulk_cnt = BW'(MAX_BULK);
        end
        else
        begin
            bulk_cnt = BW'(cmd_reg.bulk_count);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        free_next  = free_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg[AW-1:0];
        ram_wdata  = NULL_LINK;
        ram_re     = 1'b0;
        ram_raddr  = head_reg[AW-1:0];
        res_emit   = 1'b0;
        res_status = ST_DONE;
        res_last   = 1'b1;
        res_frame  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg.op)
                    OP_REBUILD:
                    begin
                        if (32'(pool_pages_reg) > 32'(POOL_DEPTH))
                        begin
                            n_next = NULL_LINK;
                        end
                        else
                        begin
                            n_next = LW'(pool_pages_reg);
                        end
                        head_next  = NULL_LINK;
                        idx_next   = '0;
                        state_next = S_LINK;
                    end
                    OP_ALLOC_ONE:
                    begin
                        cnt_next   = BW'(1);
                        k_next     = '0;
                        state_next = S_POP_RD;
                    end
                    OP_ALLOC_BULK:
                    begin
                        if (cmd_reg.bulk_count == '0)
                        begin
                            res_emit   = 1'b1;
                            res_status = ST_DONE;
                            state_next = S_IDLE;
                        end
                        else if (32'(free_reg) < 32'(bulk_cnt))
                        begin
                            res_emit   = 1'b1;
                            res_status = ST_EXHAUSTED;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cnt_next   = bulk_cnt;
                            k_next     = '0;
                            state_next = S_POP_RD;
                        end
                    end
                    OP_FREE_ONE:
                    begin
                        res_emit   = 1'b1;
                        state_next = S_IDLE;
                        if (free_bad)
                        begin
                            res_status = ST_RANGE;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = free_diff[AW-1:0];
                            ram_wdata  = head_reg;
                            head_next  = free_diff[LW-1:0];
                            res_status = ST_DONE;
                            if (free_reg < NULL_LINK)
                            begin
                                free_next = free_reg + LW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LINK:
            begin
                if (idx_reg == n_reg)
                begin
                    free_next  = n_reg;
                    total_next = n_reg;
                    res_emit   = 1'b1;
                    res_status = ST_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Each page links to the one below it; the lowest page ends the list.
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[AW-1:0];
                    ram_wdata = head_reg;
                    head_next = idx_reg;
                    idx_next  = idx_reg + LW'(1);
                end
            end
            S_POP_RD:
            begin
                if (head_reg >= NULL_LINK)
                begin
                    res_emit   = 1'b1;
                    res_status = ST_EXHAUSTED;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                head_next = ram_rdata;
                if (free_reg != '0)
                begin
                    free_next = free_reg - LW'(1);
                end
                res_emit   = 1'b1;
                res_status = ST_GIVEN;
                res_frame  = first_frame_reg + FRAME_W'(head_reg);
                res_last   = (k_reg + BW'(1) == cnt_reg);
                k_next     = k_reg + BW'(1);
                state_next = res_last ? S_IDLE : S_POP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next       = res_emit;
        res_next.frame_out   = res_frame;
        res_next.status      = res_status;
        res_next.last        = res_last;
        res_next.free_pages  = COUNT_W'(free_next);
        res_next.total_pages = COUNT_W'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_LINK;
            free_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `PFLA_ASSERT_NEXT(a_accept_busy, accept, state_reg == S_DISPATCH,
        "accepted transaction did not enter dispatch")
    `PFLA_ASSERT_NOW(a_wait_after_read, state_reg == S_POP_WAIT,
        $past(state_reg) == S_POP_RD, "link update without a preceding link read")
    `PFLA_ASSERT_NOW(a_last_idle, result_valid && result.last, !busy,
        "final result shown while the transaction is still in progress")
    `PFLA_ASSERT_NOW(a_no_page_zero, result_valid && result.status != ST_GIVEN,
        result.frame_out == '0, "result without a page carries a frame number")

endmodule

### src/pfla_ram.sv
module pfla_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
